// ----- sv/lvs_pkg.sv -----
package lvs_pkg;

    localparam int PIXEL_W     = 8;
    localparam int DIM_W       = 13;
    localparam int VAR_W       = 28;
    localparam int COUNT_W     = 24;
    localparam int CFG_INDEX_W = 4;
    localparam int RESP_W      = 11;
    localparam int SQ_W        = 21;
    localparam int FRAC_W      = 8;
    localparam int MIN_DIM     = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_A,
        B_MUL_B,
        B_MUL_D,
        B_CHECK,
        B_SAT,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

// ----- sv/lvs_front.sv -----
module lvs_front
    import lvs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT),
    localparam int CW = XW + YW,
    localparam int SW = CW + RESP_W + 1,
    localparam int QW = CW + SQ_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIXEL_W-1:0]   pixel,
    input  logic [DIM_W-1:0]     frame_width,
    input  logic [DIM_W-1:0]     frame_height,
    input  queue_status_t        q_stat,
    output logic                 push,
    output logic [CW-1:0]        push_count,
    output logic signed [SW-1:0] push_sum,
    output logic [QW-1:0]        push_sq
);

    localparam int LW = (XW + 1 > DIM_W) ? XW + 1 : DIM_W;
    localparam int LH = (YW + 1 > DIM_W) ? YW + 1 : DIM_W;

    logic               en;
    logic               accept;
    logic [LW-1:0]      fw_ext;
    logic [LW-1:0]      w_eff;
    logic [LW-1:0]      x_inc;
    logic [LH-1:0]      fh_ext;
    logic [LH-1:0]      h_eff;
    logic [LH-1:0]      y_inc;
    logic               row_end;
    logic               frame_end;
    logic               interior;

    logic [XW-1:0]      x_reg;
    logic [XW-1:0]      x_next;
    logic [YW-1:0]      y_reg;
    logic [YW-1:0]      y_next;

    logic [PIXEL_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] up_rd_reg;
    logic [PIXEL_W-1:0] mid_rd_reg;

    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [XW-1:0]      s1_addr_reg;
    logic               s1_int_reg;
    logic               s1_last_reg;

    logic [PIXEL_W-1:0] tap0_reg;
    logic [PIXEL_W-1:0] tap1_reg;
    logic [PIXEL_W-1:0] tap2_reg;
    logic [PIXEL_W-1:0] tap3_reg;
    logic signed [RESP_W-1:0] resp;

    logic               s2_valid_reg;
    logic signed [RESP_W-1:0] s2_resp_reg;
    logic               s2_int_reg;
    logic               s2_last_reg;
    logic signed [2*RESP_W-1:0] sq_full;

    logic               s3_valid_reg;
    logic signed [RESP_W-1:0] s3_resp_reg;
    logic [SQ_W-1:0]    s3_sq_reg;
    logic               s3_int_reg;
    logic               s3_last_reg;

    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] add_resp;
    logic [QW-1:0]      sq_reg;
    logic [QW-1:0]      sq_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;

    assign en       = !q_stat.full;
    assign in_ready = en;
    assign accept   = in_valid && en;

    assign fw_ext = LW'(frame_width);
    assign fh_ext = LH'(frame_height);

    always_comb
    begin
        if (fw_ext < LW'(MIN_DIM))
            w_eff = LW'(MIN_DIM);
        else if (fw_ext > LW'(MAX_WIDTH))
            w_eff = LW'(MAX_WIDTH);
        else
            w_eff = fw_ext;
    end

    always_comb
    begin
        if (fh_ext < LH'(MIN_DIM))
            h_eff = LH'(MIN_DIM);
        else if (fh_ext > LH'(MAX_HEIGHT))
            h_eff = LH'(MAX_HEIGHT);
        else
            h_eff = fh_ext;
    end

    assign x_inc     = LW'(x_reg) + LW'(1);
    assign y_inc     = LH'(y_reg) + LH'(1);
    assign row_end   = (x_inc >= w_eff);
    assign frame_end = row_end && (y_inc >= h_eff);
    assign interior  = (x_reg >= XW'(2)) && (y_reg >= YW'(2));

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (accept)
        begin
            if (row_end)
            begin
                x_next = '0;
                y_next = frame_end ? '0 : y_inc[YW-1:0];
            end
            else
            begin
                x_next = x_inc[XW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    // line stores: read at accept, write back when the item leaves stage one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg  <= upper_mem[x_reg];
            mid_rd_reg <= middle_mem[x_reg];
        end
        if (en && s1_valid_reg)
        begin
            upper_mem[s1_addr_reg]  <= mid_rd_reg;
            middle_mem[s1_addr_reg] <= s1_px_reg;
        end
    end

    assign resp = RESP_W'(tap2_reg) + RESP_W'(mid_rd_reg) + RESP_W'(tap3_reg)
                + RESP_W'(tap0_reg) - {1'b0, tap1_reg, 2'b00};

    assign sq_full = s2_resp_reg * s2_resp_reg;

    always_comb
    begin
        add_resp = s3_int_reg ? SW'(s3_resp_reg) : '0;
        sum_next = sum_reg + add_resp;
        sq_next  = sq_reg + (s3_int_reg ? QW'(s3_sq_reg) : '0);
        cnt_next = cnt_reg + CW'(s3_int_reg);
    end

    assign push       = en && s3_valid_reg && s3_last_reg;
    assign push_count = cnt_next;
    assign push_sum   = sum_next;
    assign push_sq    = sq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            tap0_reg     <= '0;
            tap1_reg     <= '0;
            tap2_reg     <= '0;
            tap3_reg     <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            cnt_reg      <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                tap0_reg <= s1_px_reg;
                tap1_reg <= mid_rd_reg;
                tap2_reg <= tap1_reg;
                tap3_reg <= up_rd_reg;
            end
            if (s3_valid_reg)
            begin
                if (s3_last_reg)
                begin
                    sum_reg <= '0;
                    sq_reg  <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    sq_reg  <= sq_next;
                    cnt_reg <= cnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_px_reg   <= pixel;
            s1_addr_reg <= x_reg;
            s1_int_reg  <= interior;
            s1_last_reg <= frame_end;
            s2_resp_reg <= resp;
            s2_int_reg  <= s1_int_reg;
            s2_last_reg <= s1_last_reg;
            s3_resp_reg <= s2_resp_reg;
            s3_sq_reg   <= sq_full[SQ_W-1:0];
            s3_int_reg  <= s2_int_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

endmodule

// ----- sv/lvs_queue.sv -----
module lvs_queue
    import lvs_pkg::*;
#(
    parameter int EW    = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [EW-1:0] push_data,
    input  logic          pop,
    output logic [EW-1:0] pop_data,
    output queue_status_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [EW-1:0]    entry_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.nonempty = (count_reg != '0);
    assign pop_data      = entry_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        if (pop)
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[tail_reg] <= push_data;
    end

endmodule

// ----- sv/lvs_back.sv -----
module lvs_back
    import lvs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT),
    localparam int CW = XW + YW,
    localparam int SW = CW + RESP_W + 1,
    localparam int QW = CW + SQ_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  queue_status_t        q_stat,
    input  logic [CW-1:0]        q_count,
    input  logic signed [SW-1:0] q_sum,
    input  logic [QW-1:0]        q_sq,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VAR_W-1:0]     variance_q8,
    output logic [COUNT_W-1:0]   interior_count
);

    localparam int PW      = 2 * SW;
    localparam int NW      = PW + FRAC_W;
    localparam int MAXSTEP = (SW > VAR_W) ? SW : VAR_W;
    localparam int STEP_W  = $clog2(MAXSTEP);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic               load_out;

    logic [STEP_W-1:0]  cnt_reg;
    logic               last_step;
    logic [CW-1:0]      n_reg;
    logic [SW-1:0]      mag_reg;
    logic [SW-1:0]      q_mag;
    logic [PW-1:0]      mcand_reg;
    logic [SW-1:0]      mplier_reg;
    logic [PW-1:0]      prod_reg;
    logic [PW-1:0]      prod_sum;
    logic [PW-1:0]      a_reg;
    logic [PW-1:0]      b_reg;
    logic [PW:0]        diff;
    logic [NW-1:0]      num_reg;
    logic [NW-1:0]      dv_reg;
    logic [NW:0]        trial;
    logic [VAR_W-1:0]   q_reg;

    logic               out_valid_reg;
    logic [VAR_W-1:0]   variance_reg;
    logic [COUNT_W-1:0] count_out_reg;

    assign q_mag     = q_sum[SW-1] ? (~q_sum + SW'(1)) : q_sum;
    assign last_step = (cnt_reg == '0);
    assign prod_sum  = prod_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign diff      = {1'b0, a_reg} - {1'b0, b_reg};
    assign trial     = {1'b0, num_reg} - {1'b0, dv_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_stat.nonempty) state_next = B_MUL_A;
            B_MUL_A: if (last_step) state_next = B_MUL_B;
            B_MUL_B: if (last_step) state_next = B_MUL_D;
            B_MUL_D: if (last_step) state_next = B_CHECK;
            B_CHECK: state_next = ((n_reg == '0) || diff[PW]) ? B_DONE : B_SAT;
            B_SAT:   state_next = trial[NW] ? B_DIV : B_DONE;
            B_DIV:   if (last_step) state_next = B_DONE;
            B_DONE:  if (!out_valid_reg || out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop = q_stat.nonempty;
            B_DONE:  load_out = !out_valid_reg || out_ready;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:  cnt_reg <= STEP_W'(CW - 1);
                B_MUL_A: cnt_reg <= last_step ? STEP_W'(SW - 1) : cnt_reg - STEP_W'(1);
                B_MUL_B: cnt_reg <= last_step ? STEP_W'(CW - 1) : cnt_reg - STEP_W'(1);
                B_MUL_D: cnt_reg <= cnt_reg - STEP_W'(1);
                B_SAT:   cnt_reg <= STEP_W'(VAR_W - 1);
                B_DIV:   cnt_reg <= cnt_reg - STEP_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // shift-add multiplies, then restoring division one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                n_reg      <= q_count;
                mag_reg    <= q_mag;
                mcand_reg  <= PW'(q_sq);
                mplier_reg <= SW'(q_count);
                prod_reg   <= '0;
            end
            B_MUL_A, B_MUL_B, B_MUL_D:
            begin
                prod_reg   <= prod_sum;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                if (last_step)
                begin
                    prod_reg <= '0;
                    if (state_reg == B_MUL_A)
                    begin
                        a_reg      <= prod_sum;
                        mcand_reg  <= PW'(mag_reg);
                        mplier_reg <= mag_reg;
                    end
                    else if (state_reg == B_MUL_B)
                    begin
                        b_reg      <= prod_sum;
                        mcand_reg  <= PW'(n_reg);
                        mplier_reg <= SW'(n_reg);
                    end
                    else
                    begin
                        dv_reg <= NW'(prod_sum) << VAR_W;
                    end
                end
            end
            B_CHECK:
            begin
                num_reg <= {diff[PW-1:0], FRAC_W'(0)};
                q_reg   <= '0;
            end
            B_SAT:
            begin
                if (!trial[NW])
                    q_reg <= '1;
                else
                    dv_reg <= dv_reg >> 1;
            end
            B_DIV:
            begin
                if (!trial[NW])
                    num_reg <= trial[NW-1:0];
                q_reg  <= {q_reg[VAR_W-2:0], !trial[NW]};
                dv_reg <= dv_reg >> 1;
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
        if (load_out)
        begin
            variance_reg  <= q_reg;
            count_out_reg <= COUNT_W'(n_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign variance_q8    = variance_reg;
    assign interior_count = count_out_reg;

endmodule

// ----- sv/laplacian_variance_sharpness_unit.sv -----
// Focus measure: variance of the 4-neighbour Laplacian over one frame.
// Input channel (in_valid/in_ready/pixel): 8-bit grayscale pixels in raster
// order. One transaction per cycle is taken while the frame statistics queue
// has room; the front pipeline is three stages deep, the first holding the line store read.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the frame
// width, index 1 the frame height, always ready; write only while idle.
// Output channel (out_valid/out_ready/variance_q8/interior_count): one
// transaction per frame, issued after the last pixel. variance_q8 has 8
// fraction bits. The last pixel's summary passes front stages s1, s2 and s3
// before it is pushed into the queue; the back end then runs its serial
// multiplier and divider (no division when the result saturates or clamps
// at zero) before the result lands in the output register. Two frame
// summaries queue up behind a busy back end.
// Reset returns to a 640x480 frame at pixel zero with the sums cleared; line
// store contents are left as they are and are rewritten before use.
// When out_ready is low the result holds; once the queue is full in_ready
// drops until the back end takes the next summary.
module laplacian_variance_sharpness_unit
    import lvs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PIXEL_W-1:0]     pixel,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VAR_W-1:0]       variance_q8,
    output logic [COUNT_W-1:0]     interior_count
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = XW + YW;
    localparam int SW = CW + RESP_W + 1;
    localparam int QW = CW + SQ_W;
    localparam int EW = CW + SW + QW;

    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;

    queue_status_t        q_stat;
    logic                 q_push;
    logic                 q_pop;
    logic [CW-1:0]        push_count;
    logic signed [SW-1:0] push_sum;
    logic [QW-1:0]        push_sq;
    logic [EW-1:0]        pop_data;
    logic [CW-1:0]        q_n;
    logic signed [SW-1:0] q_s1;
    logic [QW-1:0]        q_s2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          width_reg <= width_reg;
            endcase
        end
    end

    lvs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .q_stat       (q_stat),
        .push         (q_push),
        .push_count   (push_count),
        .push_sum     (push_sum),
        .push_sq      (push_sq)
    );

    lvs_queue #(
        .EW    (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_count, push_sum, push_sq}),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    assign q_n  = pop_data[EW-1 -: CW];
    assign q_s1 = pop_data[QW +: SW];
    assign q_s2 = pop_data[QW-1:0];

    lvs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .q_count        (q_n),
        .q_sum          (q_s1),
        .q_sq           (q_s2),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .variance_q8    (variance_q8),
        .interior_count (interior_count)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_stat.nonempty)
        else $error("frame summary popped from an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("frame summary pushed into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) q_stat.nonempty |-> (q_n != '0))
        else $error("queued frame summary has no interior samples");
`endif

endmodule

// ----- tb/laplacian_variance_sharpness_unit_tb.sv -----
module laplacian_variance_sharpness_unit_tb;
    import lvs_pkg::*;

    localparam int LINE_MAX   = 4096;
    localparam int CYCLE_CAP  = 3000000;
    localparam int SETTLE     = 400;
    localparam int HOLD_LEN   = 3000;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'd15;

    localparam int FILL_RANDOM  = 0;
    localparam int FILL_ZERO    = 1;
    localparam int FILL_FULL    = 2;
    localparam int FILL_CHECKER = 3;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [PIXEL_W-1:0]     pixel;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DIM_W-1:0]       cfg_data;
    logic                   out_valid;
    logic                   out_ready;
    logic [VAR_W-1:0]       variance_q8;
    logic [COUNT_W-1:0]     interior_count;

    laplacian_variance_sharpness_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel          (pixel),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .variance_q8    (variance_q8),
        .interior_count (interior_count)
    );

    logic [PIXEL_W-1:0] pixel_queue[$];
    logic [VAR_W-1:0]   variance_expected[$];
    logic [COUNT_W-1:0] count_expected[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned hold_req;
    int unsigned hold_seen;
    int unsigned hold_cnt;

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [PIXEL_W-1:0] upper_line[LINE_MAX];
    logic [PIXEL_W-1:0] middle_line[LINE_MAX];
    logic [PIXEL_W-1:0] taps[6];
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic signed [63:0] resp_sum;
    logic [63:0]        resp_sq_sum;
    logic [63:0]        resp_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [VAR_W-1:0] frame_variance(logic signed [63:0] s,
                                                        logic [63:0] sq, logic [63:0] n);
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] num;
        logic [127:0] q;
        logic [63:0]  mag;
        if (n == 0)
            return '0;
        mag = (s < 0) ? -s : s;
        a = {64'd0, n} * {64'd0, sq};
        b = {64'd0, mag} * {64'd0, mag};
        if (a < b)
            return '0;
        num = (a - b) << FRAC_W;
        q = num / ({64'd0, n} * {64'd0, n});
        if (q > 128'hFFFFFFF)
            return '1;
        return q[VAR_W-1:0];
    endfunction

    function automatic void predict_pixel(logic [PIXEL_W-1:0] px);
        int unsigned        w;
        int unsigned        h;
        int unsigned        xi;
        logic [PIXEL_W-1:0] up;
        logic [PIXEL_W-1:0] mid;
        logic signed [63:0] resp;
        w = clamp_dim(width_reg, LINE_MAX);
        h = clamp_dim(height_reg, LINE_MAX);
        xi = col_pos % LINE_MAX;
        up = upper_line[xi];
        mid = middle_line[xi];
        if (col_pos >= 2 && row_pos >= 2)
        begin
            resp = $signed({56'd0, taps[2]}) + $signed({56'd0, mid})
                 + $signed({56'd0, taps[3]}) + $signed({56'd0, taps[0]})
                 - 4 * $signed({56'd0, taps[1]});
            resp_sum = resp_sum + resp;
            resp_sq_sum = resp_sq_sum + 64'(resp * resp);
            resp_count = resp_count + 1;
        end
        taps[4] = up;
        taps[5] = mid;
        taps[2] = taps[1];
        taps[1] = mid;
        taps[3] = up;
        taps[0] = px;
        upper_line[xi] = mid;
        middle_line[xi] = px;
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h)
            begin
                variance_expected.push_back(frame_variance(resp_sum, resp_sq_sum,
                                                           resp_count));
                count_expected.push_back(resp_count[COUNT_W-1:0]);
                resp_sum = 0;
                resp_sq_sum = 0;
                resp_count = 0;
                row_pos = 0;
            end
            else
                row_pos = row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_pixel(pixel);
            if (!in_valid || in_ready)
            begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    pixel <= pixel_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            hold_seen <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_LEN;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (variance_expected.size() == 0)
                    report_mismatch("unexpected transaction", variance_q8, -1);
                else
                begin
                    if (variance_q8 !== variance_expected[0])
                        report_mismatch("variance_q8", variance_q8, variance_expected[0]);
                    if (interior_count !== count_expected[0])
                        report_mismatch("interior_count", interior_count,
                                        count_expected[0]);
                    void'(variance_expected.pop_front());
                    void'(count_expected.pop_front());
                end
            end
            out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = val;
        else if (idx == REG_FRAME_HEIGHT)
            height_reg = val;
    endtask

    task automatic wait_results();
        while (pixel_queue.size() > 0 || in_valid || variance_expected.size() > 0)
            @(posedge clk);
    endtask

    task automatic drain();
        wait_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic push_frame(int fill);
        int unsigned w;
        int unsigned h;
        w = clamp_dim(width_reg, LINE_MAX);
        h = clamp_dim(height_reg, LINE_MAX);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                case (fill)
                    FILL_ZERO:    pixel_queue.push_back(8'd0);
                    FILL_FULL:    pixel_queue.push_back(8'd255);
                    FILL_CHECKER: pixel_queue.push_back(((x + y) % 2) ? 8'd255 : 8'd0);
                    default:      pixel_queue.push_back(8'($urandom));
                endcase
    endtask

    initial
    begin
        int unsigned random_px;
        int unsigned frames;
        int unsigned burst;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_ready = 1'b0;
        cycle_count = 0;
        error_count = 0;
        hold_req = 0;
        send_idle_pct = 15;
        recv_idle_pct = 56;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (int i = 0; i < LINE_MAX; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            taps[i] = '0;
        col_pos = 0;
        row_pos = 0;
        resp_sum = 0;
        resp_sq_sum = 0;
        resp_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        set_dims(13'd0, 13'd1);
        push_frame(FILL_ZERO);
        push_frame(FILL_FULL);
        push_frame(FILL_RANDOM);
        set_dims(13'd5, 13'd5);
        write_reg(REG_UNUSED, 13'h1FFF);
        write_reg(REG_UNUSED, 13'h0000);
        push_frame(FILL_CHECKER);
        set_dims(13'd2, 13'd2);
        push_frame(FILL_CHECKER);

        random_px = 0;
        frames = 0;
        while (random_px < 1150)
        begin
            if (random_px < 420)
            begin
                send_idle_pct = 15;
                recv_idle_pct = 56;
            end
            else if (random_px < 840)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 15;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w = ($urandom_range(9) == 0) ? 13'($urandom_range(2)) : 13'($urandom_range(3, 12));
            h = ($urandom_range(9) == 0) ? 13'($urandom_range(2)) : 13'($urandom_range(3, 8));
            set_dims(w, h);
            burst = 4;
            if (frames == 8)
            begin
                hold_req++;
                burst = 8;
            end
            for (int f = 0; f < burst; f++)
            begin
                push_frame(FILL_RANDOM);
                random_px += clamp_dim(w, LINE_MAX) * clamp_dim(h, LINE_MAX);
                frames++;
                if (frames == 20)
                    wait_results();
            end
        end
        set_dims(WIDTH_RESET, 13'd3);
        drain();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- laplacian_variance_sharpness_unit.f -----
sv/lvs_pkg.sv
sv/lvs_front.sv
sv/lvs_queue.sv
sv/lvs_back.sv
sv/laplacian_variance_sharpness_unit.sv
tb/laplacian_variance_sharpness_unit_tb.sv
